FILE: hdl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants of the UV-sphere triangle index generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int VERTEX_W    = 16;
    localparam int COUNT_W     = 9;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_RING_COUNT       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_COUNT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTWARD_FACES    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STANDARD_WINDING = 2'd3;

    localparam logic [COUNT_W-1:0] RESET_RING_COUNT    = 9'd16;
    localparam logic [COUNT_W-1:0] RESET_SEGMENT_COUNT = 9'd16;

    typedef enum logic [2:0] {
        SEC_TOP = 3'b001,
        SEC_MID = 3'b010,
        SEC_BOT = 3'b100
    } t_section;

    typedef struct packed {
        logic outward_faces;
        logic standard_winding;
    } t_cfg_flags;

endpackage

FILE: hdl/uvs_sequencer.sv
// ----------------------------------------------------------------------------
// uvs_sequencer
// Walks the triangle list position and registers the position to emit.
// ----------------------------------------------------------------------------
module uvs_sequencer
    import uvs_pkg::*;
#(
    parameter int MAX_RINGS    = 256,
    parameter int MAX_SEGMENTS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [$clog2(MAX_RINGS+1)-1:0]      i_rings,
    input  logic [$clog2(MAX_SEGMENTS+1)-1:0]   i_segs,
    input  t_cfg_flags                          i_flags,
    input  logic                                i_list_restart,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_restart,
    output logic                                o_valid,
    input  logic                                i_ready,
    output t_section                            o_sec,
    output logic [$clog2(MAX_RINGS)-1:0]        o_band,
    output logic [$clog2(MAX_SEGMENTS)-1:0]     o_seg,
    output logic                                o_half,
    output logic                                o_last
);

    localparam int RW = $clog2(MAX_RINGS + 1);
    localparam int BW = $clog2(MAX_RINGS);
    localparam int SW = $clog2(MAX_SEGMENTS + 1);
    localparam int JW = $clog2(MAX_SEGMENTS);

    t_section        r_sec, e_sec, n_sec, m_sec, r_p_sec;
    logic [BW-1:0]   r_band, e_band, n_band, m_band, r_p_band;
    logic [JW-1:0]   r_seg, e_seg, n_seg, m_seg, r_p_seg;
    logic            r_half, e_half, n_half, m_half, r_p_half;
    logic            r_p_valid, r_p_last;
    logic            sec_ok, seg_end, accept, last;

    assign o_ready = !r_p_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        sec_ok = (r_sec == SEC_TOP) || (r_sec == SEC_MID) || (r_sec == SEC_BOT);
        e_sec  = r_sec;
        e_band = r_band;
        e_seg  = r_seg;
        e_half = r_half;
        // A stale position (e.g. the ring count shrank) falls back to the start.
        if (i_restart || !sec_ok || ((JW+1)'(r_seg) >= (JW+1)'(i_segs)) ||
            ((r_sec == SEC_MID) &&
             ((RW+1)'(r_band) + (RW+1)'(3) >= (RW+1)'(i_rings)))) begin
            e_sec  = SEC_TOP;
            e_band = '0;
            e_seg  = '0;
            e_half = 1'b0;
        end

        seg_end = ((JW+1)'(e_seg) + (JW+1)'(1)) == (JW+1)'(i_segs);
        last    = (e_sec == SEC_BOT) && seg_end;

        n_sec  = e_sec;
        n_band = e_band;
        n_seg  = e_seg + JW'(1);
        n_half = e_half;
        unique case (e_sec)
            SEC_TOP: begin
                if (seg_end) begin
                    n_seg  = '0;
                    n_half = 1'b0;
                    n_band = '0;
                    n_sec  = (i_rings > RW'(3)) ? SEC_MID : SEC_BOT;
                end
            end
            SEC_MID: begin
                if (!e_half) begin
                    n_half = 1'b1;
                    n_seg  = e_seg;
                end else begin
                    n_half = 1'b0;
                    if (seg_end) begin
                        n_seg  = '0;
                        n_band = e_band + BW'(1);
                        if ((RW+1)'(e_band) + (RW+1)'(4) >= (RW+1)'(i_rings)) begin
                            n_sec = SEC_BOT;
                        end
                    end
                end
            end
            SEC_BOT: begin
                if (seg_end) begin
                    n_sec  = SEC_TOP;
                    n_band = '0;
                    n_seg  = '0;
                    n_half = 1'b0;
                end
            end
            default: begin
                n_sec  = SEC_TOP;
                n_band = '0;
                n_seg  = '0;
                n_half = 1'b0;
            end
        endcase

        // Inward normals read the outward list from its far end.
        m_sec  = e_sec;
        m_band = e_band;
        m_seg  = e_seg;
        m_half = e_half;
        if (!i_flags.outward_faces) begin
            m_seg  = JW'(i_segs - SW'(1) - SW'(e_seg));
            m_half = !e_half;
            m_band = '0;
            unique case (e_sec)
                SEC_TOP: m_sec = SEC_BOT;
                SEC_MID: begin
                    m_sec  = SEC_MID;
                    m_band = BW'(i_rings - RW'(4) - RW'(e_band));
                end
                SEC_BOT: m_sec = SEC_TOP;
                default: m_sec = SEC_BOT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec     <= SEC_TOP;
            r_band    <= '0;
            r_seg     <= '0;
            r_half    <= 1'b0;
            r_p_valid <= 1'b0;
        end else begin
            if (i_list_restart) begin
                r_sec  <= SEC_TOP;
                r_band <= '0;
                r_seg  <= '0;
                r_half <= 1'b0;
            end else if (accept) begin
                r_sec  <= n_sec;
                r_band <= n_band;
                r_seg  <= n_seg;
                r_half <= n_half;
            end
            if (accept) begin
                r_p_valid <= 1'b1;
            end else if (i_ready) begin
                r_p_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p_sec  <= m_sec;
            r_p_band <= m_band;
            r_p_seg  <= m_seg;
            r_p_half <= m_half;
            r_p_last <= last;
        end
    end

    assign o_valid = r_p_valid;
    assign o_sec   = r_p_sec;
    assign o_band  = r_p_band;
    assign o_seg   = r_p_seg;
    assign o_half  = r_p_half;
    assign o_last  = r_p_last;

endmodule

FILE: hdl/uvs_tri_calc.sv
// ----------------------------------------------------------------------------
// uvs_tri_calc
// Turns a list position into three vertex indices and holds the result.
// ----------------------------------------------------------------------------
module uvs_tri_calc
    import uvs_pkg::*;
#(
    parameter int MAX_RINGS    = 256,
    parameter int MAX_SEGMENTS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [$clog2(MAX_RINGS+1)-1:0]      i_rings,
    input  logic [$clog2(MAX_SEGMENTS+1)-1:0]   i_segs,
    input  t_cfg_flags                          i_flags,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  t_section                            i_sec,
    input  logic [$clog2(MAX_RINGS)-1:0]        i_band,
    input  logic [$clog2(MAX_SEGMENTS)-1:0]     i_seg,
    input  logic                                i_half,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [VERTEX_W-1:0]                 o_first,
    output logic [VERTEX_W-1:0]                 o_second,
    output logic [VERTEX_W-1:0]                 o_third,
    output logic                                o_last
);

    logic [VERTEX_W-1:0] s16, nv, base, off, j16, nj16;
    logic [VERTEX_W-1:0] a, an, c, cn, t0, t1, t2;
    logic [VERTEX_W-1:0] r_first, r_second, r_third;
    logic                r_valid, r_last, load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        s16  = VERTEX_W'(i_segs);
        nv   = VERTEX_W'(2) + (VERTEX_W'(i_rings) - VERTEX_W'(2)) * s16;
        base = VERTEX_W'(1) + VERTEX_W'(i_band) * s16;
        off  = nv - s16 - VERTEX_W'(1);
        j16  = VERTEX_W'(i_seg);
        // The segment after the last one wraps round to segment zero.
        nj16 = ((j16 + VERTEX_W'(1)) == s16) ? '0 : (j16 + VERTEX_W'(1));
        a    = base + j16;
        an   = base + nj16;
        c    = base + s16 + j16;
        cn   = base + s16 + nj16;

        unique case (i_sec)
            SEC_MID: begin
                if (!i_half) begin
                    t0 = a;
                    t1 = i_flags.standard_winding ? an : c;
                    t2 = i_flags.standard_winding ? c : an;
                end else begin
                    t0 = c;
                    t1 = an;
                    t2 = cn;
                end
            end
            SEC_BOT: begin
                t0 = nv - VERTEX_W'(1);
                t1 = i_flags.standard_winding ? off + j16 : off + nj16;
                t2 = i_flags.standard_winding ? off + nj16 : off + j16;
            end
            default: begin
                t0 = '0;
                t1 = VERTEX_W'(1) + nj16;
                t2 = VERTEX_W'(1) + j16;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // A reversed list also reverses the index order within each triangle.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_first  <= i_flags.outward_faces ? t0 : t2;
            r_second <= t1;
            r_third  <= i_flags.outward_faces ? t2 : t0;
            r_last   <= i_last;
        end
    end

    assign o_valid  = r_valid;
    assign o_first  = r_first;
    assign o_second = r_second;
    assign o_third  = r_third;
    assign o_last   = r_last;

endmodule

FILE: hdl/uv_sphere_index_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_index_generator
// Streams the triangle index list of a latitude-longitude sphere mesh.
// ----------------------------------------------------------------------------
// Each input transaction requests one triangle (bit 0 of the data restarts the
// list) and yields exactly one result transaction carrying three 16-bit vertex
// indices, with tlast on the final triangle. One triangle is accepted every
// clock cycle unless the result side stalls; each request passes through the
// position register of the sequencer and then the result register behind the index
// arithmetic (two 16-bit multipliers). Any configuration write restarts the
// list and should only be issued while no requests are outstanding.
module uv_sphere_index_generator
    import uvs_pkg::*;
#(
    parameter int MAX_RINGS    = 256,
    parameter int MAX_SEGMENTS = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Requests
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,   // [0] restart, [7:1] zero
    // Triangles
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [3*VERTEX_W-1:0]  o_m_axis_tdata,   // first, second, third vertex
    output logic                   o_m_axis_tlast,   // last_triangle
    // Configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [COUNT_W-1:0]     i_cfg_data
);

    localparam int RW = $clog2(MAX_RINGS + 1);
    localparam int BW = $clog2(MAX_RINGS);
    localparam int SW = $clog2(MAX_SEGMENTS + 1);
    localparam int JW = $clog2(MAX_SEGMENTS);

    logic [COUNT_W-1:0]  r_ring_count, r_segment_count;
    t_cfg_flags          r_flags;
    logic [RW-1:0]       rings;
    logic [SW-1:0]       segs;
    logic                list_restart;

    logic                p_valid, p_ready, p_half, p_last;
    t_section            p_sec;
    logic [BW-1:0]       p_band;
    logic [JW-1:0]       p_seg;
    logic [VERTEX_W-1:0] v_first, v_second, v_third;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_count             <= RESET_RING_COUNT;
            r_segment_count          <= RESET_SEGMENT_COUNT;
            r_flags.outward_faces    <= 1'b1;
            r_flags.standard_winding <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RING_COUNT:       r_ring_count             <= i_cfg_data;
                CFG_SEGMENT_COUNT:    r_segment_count          <= i_cfg_data;
                CFG_OUTWARD_FACES:    r_flags.outward_faces    <= i_cfg_data[0];
                CFG_STANDARD_WINDING: r_flags.standard_winding <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_cfg_index)
            CFG_RING_COUNT, CFG_SEGMENT_COUNT,
            CFG_OUTWARD_FACES, CFG_STANDARD_WINDING: list_restart = i_cfg_valid;
            default:                                 list_restart = 1'b0;
        endcase
    end

    // Counts outside the supported range saturate.
    always_comb begin
        if (r_ring_count < COUNT_W'(3)) begin
            rings = RW'(3);
        end else if (r_ring_count > MAX_RINGS) begin
            rings = RW'(MAX_RINGS);
        end else begin
            rings = RW'(r_ring_count);
        end
        if (r_segment_count < COUNT_W'(3)) begin
            segs = SW'(3);
        end else if (r_segment_count > MAX_SEGMENTS) begin
            segs = SW'(MAX_SEGMENTS);
        end else begin
            segs = SW'(r_segment_count);
        end
    end

    uvs_sequencer #(
        .MAX_RINGS    (MAX_RINGS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_sequencer (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rings        (rings),
        .i_segs         (segs),
        .i_flags        (r_flags),
        .i_list_restart (list_restart),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_restart      (i_s_axis_tdata[0]),
        .o_valid        (p_valid),
        .i_ready        (p_ready),
        .o_sec          (p_sec),
        .o_band         (p_band),
        .o_seg          (p_seg),
        .o_half         (p_half),
        .o_last         (p_last)
    );

    uvs_tri_calc #(
        .MAX_RINGS    (MAX_RINGS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_tri_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rings  (rings),
        .i_segs   (segs),
        .i_flags  (r_flags),
        .i_valid  (p_valid),
        .o_ready  (p_ready),
        .i_sec    (p_sec),
        .i_band   (p_band),
        .i_seg    (p_seg),
        .i_half   (p_half),
        .i_last   (p_last),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_first  (v_first),
        .o_second (v_second),
        .o_third  (v_third),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {v_third, v_second, v_first};

endmodule

FILE: hdl/uvs_checker.sv
// ----------------------------------------------------------------------------
// uvs_checker
// Port-level checks of the sphere index generator, bound to the top level.
// ----------------------------------------------------------------------------
module uvs_checker
    import uvs_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [3*VERTEX_W-1:0]  o_m_axis_tdata,
    input logic                   o_m_axis_tlast,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready
);

    // A stalled result transaction holds its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("stalled result changed");

    // With the result register empty, the request side can never be blocked.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("request stalled with empty result register");

    // A result register that fills from empty was fed by a request through the position register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready, 2))
        else $error("result appeared without a request");

    // Configuration writes are always taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind uv_sphere_index_generator uvs_checker u_uvs_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the UV-sphere triangle index generator.
// ----------------------------------------------------------------------------
// Requests are streamed into the block while a local model of the mesh
// sequencer predicts every triangle. Each result transaction is checked field
// by field against the oldest prediction. The run starts with short directed
// lists (default counts, three rings, reversed small mesh, saturated counts)
// and then moves on to random mesh shapes under several idling patterns. It
// also holds the result side off long enough to make the block stall its
// request side.
// ----------------------------------------------------------------------------
module tb_top
    import uvs_pkg::*;
();

    localparam int MAX_RINGS      = 256;
    localparam int MAX_SEGMENTS   = 256;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [VERTEX_W-1:0] first_vertex;
        logic [VERTEX_W-1:0] second_vertex;
        logic [VERTEX_W-1:0] third_vertex;
        logic                last_triangle;
    } t_sphere_triangle;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [7:0]             i_s_axis_tdata = '0;   // [0] restart, [7:1] zero
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [3*VERTEX_W-1:0]  o_m_axis_tdata;        // first, second, third vertex
    logic                   o_m_axis_tlast;        // last_triangle
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [COUNT_W-1:0]     i_cfg_data = '0;

    // Model of the mesh sequencer: configuration and list position.
    logic [COUNT_W-1:0] ring_reg;
    logic [COUNT_W-1:0] segment_reg;
    logic               outward_reg;
    logic               winding_reg;
    t_section           pos_section;
    int                 pos_band;
    int                 pos_segment;
    bit                 pos_half;

    t_sphere_triangle triangle_queue[$];
    t_sphere_triangle expected_triangle;
    int               failures = 0;
    int               idle_cycles = 0;
    int               sender_idle_pct = 0;
    int               receiver_stall_pct = 0;
    logic             long_hold = 1'b0;
    int               hold_count = 0;

    uv_sphere_index_generator #(
        .MAX_RINGS    (MAX_RINGS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void rewind_list();
        pos_section = SEC_TOP;
        pos_band    = 0;
        pos_segment = 0;
        pos_half    = 1'b0;
    endfunction

    // Vertex indices of one triangle, addressed by its place in the outward list.
    function automatic void triangle_at(input t_section sec, input int band, input int seg,
                                        input bit half, input int rings, input int segs,
                                        input bit std_w, output int v0, output int v1,
                                        output int v2);
        int vertex_count;
        int next_seg;
        int base;
        int ring_off;
        vertex_count = 2 + (rings - 2) * segs;
        next_seg     = (seg + 1 == segs) ? 0 : seg + 1;
        case (sec)
            SEC_MID: begin
                base = 1 + band * segs;
                if (!half) begin
                    v0 = base + seg;
                    v1 = std_w ? base + next_seg : base + segs + seg;
                    v2 = std_w ? base + segs + seg : base + next_seg;
                end else begin
                    v0 = base + segs + seg;
                    v1 = base + next_seg;
                    v2 = base + segs + next_seg;
                end
            end
            SEC_BOT: begin
                ring_off = vertex_count - segs - 1;
                v0 = vertex_count - 1;
                v1 = std_w ? ring_off + seg : ring_off + next_seg;
                v2 = std_w ? ring_off + next_seg : ring_off + seg;
            end
            default: begin
                v0 = 0;
                v1 = 1 + next_seg;
                v2 = 1 + seg;
            end
        endcase
    endfunction

    // Works out the triangle answered to one request and moves the position on.
    function automatic t_sphere_triangle next_triangle(input bit restart);
        int               rings;
        int               segs;
        int               v0;
        int               v1;
        int               v2;
        t_section         mirror_sec;
        t_sphere_triangle result;
        rings = (ring_reg < 3) ? 3 : (ring_reg > MAX_RINGS) ? MAX_RINGS : int'(ring_reg);
        segs  = (segment_reg < 3) ? 3 :
                (segment_reg > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(segment_reg);

        if (restart || pos_segment >= segs || (pos_section == SEC_MID && pos_band + 3 >= rings))
            rewind_list();

        if (outward_reg) begin
            triangle_at(pos_section, pos_band, pos_segment, pos_half, rings, segs,
                        winding_reg, v0, v1, v2);
            result.first_vertex  = v0[VERTEX_W-1:0];
            result.second_vertex = v1[VERTEX_W-1:0];
            result.third_vertex  = v2[VERTEX_W-1:0];
        end else begin
            // Inward normals: the mirrored place in the list, indices reversed.
            mirror_sec = (pos_section == SEC_TOP) ? SEC_BOT :
                         (pos_section == SEC_BOT) ? SEC_TOP : SEC_MID;
            triangle_at(mirror_sec, (pos_section == SEC_MID) ? rings - 4 - pos_band : 0,
                        segs - 1 - pos_segment, !pos_half, rings, segs, winding_reg,
                        v0, v1, v2);
            result.first_vertex  = v2[VERTEX_W-1:0];
            result.second_vertex = v1[VERTEX_W-1:0];
            result.third_vertex  = v0[VERTEX_W-1:0];
        end
        result.last_triangle = (pos_section == SEC_BOT && pos_segment + 1 == segs);

        case (pos_section)
            SEC_MID: begin
                if (!pos_half) begin
                    pos_half = 1'b1;
                end else begin
                    pos_half = 1'b0;
                    pos_segment++;
                    if (pos_segment == segs) begin
                        pos_segment = 0;
                        pos_band++;
                        if (pos_band + 3 >= rings)
                            pos_section = SEC_BOT;
                    end
                end
            end
            SEC_BOT: begin
                pos_segment++;
                if (pos_segment == segs)
                    rewind_list();
            end
            default: begin
                pos_segment++;
                if (pos_segment == segs) begin
                    pos_segment = 0;
                    pos_half    = 1'b0;
                    pos_band    = 0;
                    pos_section = (rings > 3) ? SEC_MID : SEC_BOT;
                end
            end
        endcase
        return result;
    endfunction

    // Checks each result transaction, then predicts the result of each request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_reg    = RESET_RING_COUNT;
            segment_reg = RESET_SEGMENT_COUNT;
            outward_reg = 1'b1;
            winding_reg = 1'b1;
            rewind_list();
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (triangle_queue.size() == 0) begin
                    $error("unexpected triangle %h, last %b", o_m_axis_tdata, o_m_axis_tlast);
                    failures++;
                end else begin
                    expected_triangle = triangle_queue.pop_front();
                    if (o_m_axis_tdata[VERTEX_W-1:0] !== expected_triangle.first_vertex) begin
                        $error("first_vertex: expected %0d, actual %0d",
                               expected_triangle.first_vertex, o_m_axis_tdata[VERTEX_W-1:0]);
                        failures++;
                    end
                    if (o_m_axis_tdata[2*VERTEX_W-1:VERTEX_W] !==
                        expected_triangle.second_vertex) begin
                        $error("second_vertex: expected %0d, actual %0d",
                               expected_triangle.second_vertex,
                               o_m_axis_tdata[2*VERTEX_W-1:VERTEX_W]);
                        failures++;
                    end
                    if (o_m_axis_tdata[3*VERTEX_W-1:2*VERTEX_W] !==
                        expected_triangle.third_vertex) begin
                        $error("third_vertex: expected %0d, actual %0d",
                               expected_triangle.third_vertex,
                               o_m_axis_tdata[3*VERTEX_W-1:2*VERTEX_W]);
                        failures++;
                    end
                    if (o_m_axis_tlast !== expected_triangle.last_triangle) begin
                        $error("last_triangle: expected %0d, actual %0d",
                               expected_triangle.last_triangle, o_m_axis_tlast);
                        failures++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                triangle_queue = {triangle_queue, next_triangle(i_s_axis_tdata[0])};
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RING_COUNT:       ring_reg    = i_cfg_data;
                    CFG_SEGMENT_COUNT:    segment_reg = i_cfg_data;
                    CFG_OUTWARD_FACES:    outward_reg = i_cfg_data[0];
                    CFG_STANDARD_WINDING: winding_reg = i_cfg_data[0];
                    default: ;
                endcase
                rewind_list();
            end
        end
    end

    // Result side: random stalls, or a long hold-off while long_hold is raised.
    always @(posedge i_clk) begin
        if (long_hold && hold_count < HOLD_CYCLES) begin
            hold_count      <= hold_count + 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (!long_hold)
                hold_count <= 0;
            i_m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL uv_sphere_index_generator");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one request and returns at the edge where it is accepted.
    task automatic send_request(input bit restart);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'b0, restart};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // One edge first, so that the last accepted request is already queued.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (triangle_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [COUNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Flags take the whole data word; only bit 0 counts.
    task automatic configure(input logic [COUNT_W-1:0] rings, input logic [COUNT_W-1:0] segs,
                             input logic [COUNT_W-1:0] outward,
                             input logic [COUNT_W-1:0] winding);
        drain_results();
        write_register(CFG_RING_COUNT, rings);
        write_register(CFG_SEGMENT_COUNT, segs);
        write_register(CFG_OUTWARD_FACES, outward);
        write_register(CFG_STANDARD_WINDING, winding);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [COUNT_W-1:0] random_count();
        case ($urandom_range(9))
            0: return COUNT_W'($urandom_range(2));
            1: return COUNT_W'($urandom_range(511, 257));
            2: return COUNT_W'($urandom_range(256, 7));
            default: return COUNT_W'($urandom_range(6, 3));
        endcase
    endfunction

    task automatic test_reset_values();
        send_request(1'b0);
        send_request(1'b1);
    endtask

    // Ring count below range saturates to three: no middle bands at all.
    task automatic test_three_rings();
        configure(9'd2, 9'd3, 9'd1, 9'd1);
        repeat (7) send_request(1'b0);
    endtask

    // Smallest mesh with a middle band, reversed, other winding; ends on a restart.
    task automatic test_reversed_list();
        configure(9'd4, 9'd0, 9'h1FE, 9'h1FE);
        repeat (12) send_request(1'b0);
        send_request(1'b1);
    endtask

    // Both counts saturate to the maximum; reversed order opens on the highest indices.
    task automatic test_largest_sphere();
        configure(9'h1FF, 9'd300, 9'h100, 9'h0FF);
        send_request(1'b0);
        send_request(1'b0);
    endtask

    task automatic test_random_lists(input int sender_pct, input int receiver_pct);
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
        repeat (2) begin
            configure(random_count(), random_count(), COUNT_W'($urandom_range(511)),
                      COUNT_W'($urandom_range(511)));
            repeat (28) send_request($urandom_range(99) < 3);
        end
    endtask

    // The result side holds off while requests keep coming, so the block fills up.
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        configure(9'd5, 9'd4, 9'd1, 9'd0);
        long_hold <= 1'b1;
        repeat (40) send_request(1'b0);
        long_hold <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_three_rings();
        test_reversed_list();
        test_largest_sphere();
        test_random_lists(0, 0);
        test_random_lists(63, 0);
        test_random_lists(0, 63);
        test_random_lists(14, 14);
        test_backpressure();
        test_random_lists(0, 0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (triangle_queue.size() != 0) begin
            $error("%0d triangles never arrived", triangle_queue.size());
            failures++;
        end
        if (failures == 0) begin
            $display("PASS uv_sphere_index_generator");
        end else begin
            $display("FAIL uv_sphere_index_generator");
        end
        $finish;
    end

endmodule
